[rtl/pdb_pkg.sv]
// Package for the Porter-Duff pixel blender: mode codes, blend control struct,
// factor selection and the rounded divide-by-255 helper.
// No dependencies.
package pdb_pkg;

    localparam int unsigned CH_W    = 8;
    localparam int unsigned NUM_CH  = 4;
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam int unsigned MODE_W  = 4;

    // Register index, taken from paddr[2] (registers sit on 4-byte steps)
    localparam logic REG_BLEND_MODE = 1'b0;

    localparam logic [CH_W-1:0] ALPHA_ZERO = 8'd0;
    localparam logic [CH_W-1:0] ALPHA_FULL = 8'd255;

    // Channel order inside a pixel
    localparam int unsigned CH_ALPHA = 0;
    localparam int unsigned CH_RED   = 1;
    localparam int unsigned CH_GREEN = 2;
    localparam int unsigned CH_BLUE  = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR       = 4'd0,
        MODE_SRC         = 4'd1,
        MODE_DST         = 4'd2,
        MODE_SOURCE_OVER = 4'd3,
        MODE_DST_OVER    = 4'd4,
        MODE_SRC_IN      = 4'd5,
        MODE_DST_IN      = 4'd6,
        MODE_SRC_OUT     = 4'd7,
        MODE_DST_OUT     = 4'd8,
        MODE_SRC_ATOP    = 4'd9,
        MODE_DST_ATOP    = 4'd10,
        MODE_XOR         = 4'd11
    } t_blend_mode;

    // Weight applied to one side: zero, one (255), the other side's alpha,
    // or one minus the other side's alpha
    typedef enum logic [1:0] {
        F_ZERO,
        F_ONE,
        F_ALPHA,
        F_INV
    } t_factor;

    // Per-pixel control from the mode decoder to every channel lane
    typedef struct packed {
        logic [CH_W-1:0] src_factor;
        logic [CH_W-1:0] dst_factor;
        logic            joint;      // round the summed products once
    } t_blend_ctl;

    function automatic logic [CH_W-1:0] factor_value(input t_factor sel,
                                                     input logic [CH_W-1:0] alpha);
        logic [CH_W-1:0] val;
        unique case (sel)
            F_ZERO:  val = ALPHA_ZERO;
            F_ONE:   val = ALPHA_FULL;
            F_ALPHA: val = alpha;
            F_INV:   val = ~alpha;
            default: val = ALPHA_ZERO;
        endcase
        return val;
    endfunction

    // round(x / 255) as ((x + 128) * 257) >> 16, with *257 as a shifted add
    function automatic logic [8:0] div255(input logic [16:0] x);
        logic [17:0] biased;
        logic [25:0] scaled;
        biased = {1'b0, x} + 18'd128;
        scaled = {biased, 8'b0} + {8'b0, biased};
        return scaled[24:16];
    endfunction

endpackage

[rtl/pdb_mode_decode.sv]
// Mode decoder: turns the blend mode and the two alphas into per-side weights.
// Depends on pdb_pkg.
module pdb_mode_decode (
    input  pdb_pkg::t_blend_mode        i_mode,
    input  logic [pdb_pkg::CH_W-1:0]    i_src_alpha,
    input  logic [pdb_pkg::CH_W-1:0]    i_dst_alpha,
    output pdb_pkg::t_blend_ctl         o_ctl
);
    import pdb_pkg::*;

    logic    sa_zero, sa_full, da_zero, da_full;
    t_factor src_sel, dst_sel;
    logic    joint;

    assign sa_zero = (i_src_alpha == ALPHA_ZERO);
    assign sa_full = (i_src_alpha == ALPHA_FULL);
    assign da_zero = (i_dst_alpha == ALPHA_ZERO);
    assign da_full = (i_dst_alpha == ALPHA_FULL);

    // A plain copy is weight one on that side (exact through div255);
    // copying a side with zero alpha gives zero.
    always_comb begin
        src_sel = F_ZERO;
        dst_sel = F_ZERO;
        joint   = 1'b0;
        unique case (i_mode)
            MODE_CLEAR: begin
            end
            MODE_SRC: begin
                src_sel = sa_zero ? F_ZERO : F_ONE;
            end
            MODE_DST: begin
                dst_sel = da_zero ? F_ZERO : F_ONE;
            end
            MODE_SOURCE_OVER: begin
                priority if (sa_zero) begin
                    dst_sel = da_zero ? F_ZERO : F_ONE;
                end else if (sa_full || da_zero) begin
                    src_sel = F_ONE;
                end else begin
                    src_sel = F_ONE;
                    dst_sel = F_INV;
                end
            end
            MODE_DST_OVER: begin
                priority if (sa_zero) begin
                    dst_sel = da_zero ? F_ZERO : F_ONE;
                end else if (da_zero) begin
                    src_sel = F_ONE;
                end else if (da_full) begin
                    dst_sel = F_ONE;
                end else begin
                    src_sel = F_INV;
                    dst_sel = F_ONE;
                end
            end
            MODE_SRC_IN: begin
                priority if (sa_zero || da_zero) begin
                end else if (da_full) begin
                    src_sel = F_ONE;
                end else begin
                    src_sel = F_ALPHA;
                end
            end
            MODE_DST_IN: begin
                priority if (sa_zero) begin
                end else if (sa_full) begin
                    dst_sel = da_zero ? F_ZERO : F_ONE;
                end else if (da_zero) begin
                end else begin
                    dst_sel = F_ALPHA;
                end
            end
            MODE_SRC_OUT: begin
                priority if (sa_zero) begin
                end else if (da_zero) begin
                    src_sel = F_ONE;
                end else if (da_full) begin
                end else begin
                    src_sel = F_INV;
                end
            end
            MODE_DST_OUT: begin
                priority if (sa_zero) begin
                    dst_sel = da_zero ? F_ZERO : F_ONE;
                end else if (sa_full || da_zero) begin
                end else begin
                    dst_sel = F_INV;
                end
            end
            MODE_SRC_ATOP: begin
                priority if (sa_zero) begin
                    dst_sel = da_zero ? F_ZERO : F_ONE;
                end else if (da_zero) begin
                end else if (sa_full) begin
                    src_sel = da_full ? F_ONE : F_ALPHA;
                end else begin
                    src_sel = F_ALPHA;
                    dst_sel = F_INV;
                end
            end
            MODE_DST_ATOP: begin
                priority if (sa_zero) begin
                end else if (da_zero) begin
                    src_sel = F_ONE;
                end else if (sa_full && da_full) begin
                    dst_sel = F_ONE;
                end else if (sa_full) begin
                    src_sel = F_INV;
                    dst_sel = F_ONE;
                end else if (da_full) begin
                    dst_sel = F_ALPHA;
                end else begin
                    src_sel = F_INV;
                    dst_sel = F_ALPHA;
                end
            end
            MODE_XOR: begin
                priority if (sa_zero) begin
                    dst_sel = da_zero ? F_ZERO : F_ONE;
                end else if (da_zero) begin
                    src_sel = F_ONE;
                end else if (da_full) begin
                    dst_sel = sa_full ? F_ZERO : F_INV;
                end else if (sa_full) begin
                    src_sel = F_INV;
                end else begin
                    src_sel = F_INV;
                    dst_sel = F_INV;
                    joint   = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Source side is weighted by the destination alpha and vice versa
    assign o_ctl.src_factor = factor_value(src_sel, i_dst_alpha);
    assign o_ctl.dst_factor = factor_value(dst_sel, i_src_alpha);
    assign o_ctl.joint      = joint;

endmodule

[rtl/pdb_channel.sv]
// One channel lane: two weighted products, rounded divide by 255, saturate.
// Depends on pdb_pkg.
module pdb_channel (
    input  logic [pdb_pkg::CH_W-1:0] i_src_val,
    input  logic [pdb_pkg::CH_W-1:0] i_dst_val,
    input  pdb_pkg::t_blend_ctl      i_ctl,
    output logic [pdb_pkg::CH_W-1:0] o_val
);
    import pdb_pkg::*;

    logic [15:0] src_prod, dst_prod;
    logic [16:0] prod_sum;
    logic [8:0]  split_res, joint_res, res;

    assign src_prod = {8'b0, i_src_val} * {8'b0, i_ctl.src_factor};
    assign dst_prod = {8'b0, i_dst_val} * {8'b0, i_ctl.dst_factor};
    assign prod_sum = {1'b0, src_prod} + {1'b0, dst_prod};

    assign split_res = div255({1'b0, src_prod}) + div255({1'b0, dst_prod});
    assign joint_res = div255(prod_sum);
    assign res       = i_ctl.joint ? joint_res : split_res;

    // Clamp: only reachable with colour above alpha
    assign o_val = res[8] ? ALPHA_FULL : res[CH_W-1:0];

endmodule

[rtl/porter_duff_pixel_blend.sv]
// Top level of the Porter-Duff pixel blender: APB mode register, input
// register, blend datapath and result register.
// Depends on pdb_pkg, pdb_mode_decode and pdb_channel.
//
//  channel   handshake                   payload
//  -------   -------------------------   ---------------------------------------
//  input     i_in_valid / o_in_ready     i_src_{alpha,red,green,blue},
//                                        i_dst_{alpha,red,green,blue}
//  output    o_out_valid / i_out_ready   o_out_{alpha,red,green,blue}
//  config    psel/penable/pwrite/pready  paddr, pwdata, prdata (blend_mode @ 0x0)
//
// One pixel per cycle sustained while the output is not stalled. An accepted
// transaction is held in the input register, then in the result register, and
// shows on o_out_* from there. Cost per cycle is set by the blend stage: one 8x8
// product pair, the rounded divide by 255 and a saturate per channel.
// Synchronous active-low reset empties both registers and sets source-over.
// A stall on the output holds the result register; the input register still
// drains into it as soon as the result is taken, so a full pipe takes a new
// transaction on the very cycle the old result leaves.
module porter_duff_pixel_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pdb_pkg::PADDR_W-1:0]   paddr,
    input  logic [pdb_pkg::PDATA_W-1:0]   pwdata,
    output logic [pdb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    // input pixels
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pdb_pkg::CH_W-1:0]      i_src_alpha,
    input  logic [pdb_pkg::CH_W-1:0]      i_src_red,
    input  logic [pdb_pkg::CH_W-1:0]      i_src_green,
    input  logic [pdb_pkg::CH_W-1:0]      i_src_blue,
    input  logic [pdb_pkg::CH_W-1:0]      i_dst_alpha,
    input  logic [pdb_pkg::CH_W-1:0]      i_dst_red,
    input  logic [pdb_pkg::CH_W-1:0]      i_dst_green,
    input  logic [pdb_pkg::CH_W-1:0]      i_dst_blue,
    // blended pixels
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pdb_pkg::CH_W-1:0]      o_out_alpha,
    output logic [pdb_pkg::CH_W-1:0]      o_out_red,
    output logic [pdb_pkg::CH_W-1:0]      o_out_green,
    output logic [pdb_pkg::CH_W-1:0]      o_out_blue
);
    import pdb_pkg::*;

    // ---------------------------------------------------------------
    // Mode register
    // ---------------------------------------------------------------
    t_blend_mode r_mode;
    logic        reg_sel;
    logic        mode_wr;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_BLEND_MODE);
    assign mode_wr = psel && penable && pwrite && pready && reg_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SOURCE_OVER;
        end else if (mode_wr) begin
            r_mode <= t_blend_mode'(pwdata[MODE_W-1:0]);
        end
    end

    // Read back the mode; unmapped addresses read as zero
    assign prdata = reg_sel ? {{(PDATA_W-MODE_W){1'b0}}, r_mode} : '0;

    // ---------------------------------------------------------------
    // Handshake: the result stage frees up as soon as its transaction is
    // taken, and the input stage advances whenever the result stage frees.
    // ---------------------------------------------------------------
    logic r_in_valid, n_in_valid;
    logic r_out_valid, n_out_valid;
    logic out_free;
    logic in_take;
    logic in_adv;

    assign out_free   = !r_out_valid || i_out_ready;
    assign in_adv     = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_take    = i_in_valid && o_in_ready;

    assign n_in_valid  = in_take || (r_in_valid && !out_free);
    assign n_out_valid = in_adv || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // ---------------------------------------------------------------
    // Input register: hold the pixel pair until it moves on
    // ---------------------------------------------------------------
    logic [CH_W-1:0] r_src [NUM_CH];
    logic [CH_W-1:0] r_dst [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_src[CH_ALPHA] <= i_src_alpha;
            r_src[CH_RED]   <= i_src_red;
            r_src[CH_GREEN] <= i_src_green;
            r_src[CH_BLUE]  <= i_src_blue;
            r_dst[CH_ALPHA] <= i_dst_alpha;
            r_dst[CH_RED]   <= i_dst_red;
            r_dst[CH_GREEN] <= i_dst_green;
            r_dst[CH_BLUE]  <= i_dst_blue;
        end
    end

    // ---------------------------------------------------------------
    // Blend: decode the weights from the alphas, then run all four
    // channels (alpha included) through identical lanes
    // ---------------------------------------------------------------
    t_blend_ctl      blend_ctl;
    logic [CH_W-1:0] blend_val [NUM_CH];

    pdb_mode_decode u_mode_decode (
        .i_mode      (r_mode),
        .i_src_alpha (r_src[CH_ALPHA]),
        .i_dst_alpha (r_dst[CH_ALPHA]),
        .o_ctl       (blend_ctl)
    );

    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        pdb_channel u_channel (
            .i_src_val (r_src[ch]),
            .i_dst_val (r_dst[ch]),
            .i_ctl     (blend_ctl),
            .o_val     (blend_val[ch])
        );
    end

    // ---------------------------------------------------------------
    // Result register: load on advance, hold while the sink stalls
    // ---------------------------------------------------------------
    logic [CH_W-1:0] r_res [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (in_adv) begin
            r_res <= blend_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_alpha = r_res[CH_ALPHA];
    assign o_out_red   = r_res[CH_RED];
    assign o_out_green = r_res[CH_GREEN];
    assign o_out_blue  = r_res[CH_BLUE];

endmodule

[rtl/pdb_checker.sv]
// Port-level checker for the Porter-Duff pixel blender, bound to the top level.
// Depends on pdb_pkg and porter_duff_pixel_blend.
module pdb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [pdb_pkg::PADDR_W-1:0]   paddr,
    input logic [pdb_pkg::PDATA_W-1:0]   pwdata,
    input logic [pdb_pkg::PDATA_W-1:0]   prdata,
    input logic                          pready,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [pdb_pkg::CH_W-1:0]      o_out_alpha,
    input logic [pdb_pkg::CH_W-1:0]      o_out_red,
    input logic [pdb_pkg::CH_W-1:0]      o_out_green,
    input logic [pdb_pkg::CH_W-1:0]      o_out_blue
);
    import pdb_pkg::*;

    // Reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_alpha)
            && $stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue))
        else $error("stalled result changed");

    // A result that appears in an empty pipe came from a transaction through the input register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without matching input transaction");

    // Mode write reads back on the next access
    a_mode_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_BLEND_MODE)
        |=> (paddr[2] != REG_BLEND_MODE)
            || (prdata[MODE_W-1:0] == $past(pwdata[MODE_W-1:0])))
        else $error("mode register read-back mismatch");

endmodule

bind porter_duff_pixel_blend pdb_checker u_pdb_checker (.*);
